>>> design/twtl_pkg.sv
// Shared types, constants and codes of the text wrap and tab layout block.
package twtl_pkg;

  // Tab stop spacing and the derived widths of the tab counters.
  localparam int TAB_STOP = 4;
  localparam int TPH_W    = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
  localparam int TCNT_W   = $clog2(TAB_STOP + 1);

  // Field and state widths.
  localparam int LC_W   = 17;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 6;
  localparam int GLY_W  = 7;
  localparam int BYTE_W = 8;
  localparam int FL_W   = 16;
  localparam int WR_W   = 7;
  localparam int LW_W   = 7;

  // Saturation value of the line counter and the largest window.
  localparam logic [LC_W-1:0] LINE_MAX = 17'h1FFFF;
  localparam logic [WR_W-1:0] ROWS_MAX = 7'd64;

  // Depth of the command queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Configuration register indexes and reset values.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_LINE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_ROWS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH  = 2'd2;
  localparam logic [FL_W-1:0] FIRST_LINE_RST  = 16'd0;
  localparam logic [WR_W-1:0] WINDOW_ROWS_RST = 7'd28;
  localparam logic [LW_W-1:0] LINE_WIDTH_RST  = 7'd77;

  // Input operation codes.
  localparam logic OP_TEXT    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // Character codes.
  localparam logic [BYTE_W-1:0] CH_NL      = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR      = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_TAB     = 8'h09;
  localparam logic [BYTE_W-1:0] CH_PRINT_LO = 8'd32;
  localparam logic [BYTE_W-1:0] CH_PRINT_HI = 8'd126;
  localparam logic [GLY_W-1:0]  GLYPH_DOT   = 7'h2E;
  localparam logic [GLY_W-1:0]  GLYPH_SPACE = 7'd32;
  localparam logic [GLY_W-1:0]  GLYPH_LO    = 7'd32;
  localparam logic [GLY_W-1:0]  GLYPH_HI    = 7'd126;

  // Command kinds handed from the front to the back.
  typedef enum logic [1:0] {
    KIND_GLYPH   = 2'd0,
    KIND_TAB     = 2'd1,
    KIND_NEWLINE = 2'd2,
    KIND_RESTART = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [GLY_W-1:0]  glyph;
  } cmd_t;

  // Layout settings as the back sees them, already clamped.
  typedef struct packed {
    logic [FL_W-1:0] first_line;
    logic [LC_W-1:0] window_end;
    logic [LW_W-1:0] width;
  } layout_cfg_t;

endpackage

>>> design/twtl_front.sv
// Front end: accepts input words and classifies them into layout commands.
module twtl_front import twtl_pkg::*; (
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              op_i,
  input  logic [BYTE_W-1:0] data_byte_i,
  input  logic              q_full_i,
  output logic              push_o,
  output cmd_t              cmd_o
);

  logic accept;
  logic printable;

  // A word is taken whenever the queue has room.
  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign printable  = (data_byte_i >= CH_PRINT_LO) && (data_byte_i <= CH_PRINT_HI);

  // Classify the word; a carriage return is dropped here and never queued.
  always_comb begin
    cmd_o.kind  = KIND_GLYPH;
    cmd_o.glyph = printable ? data_byte_i[GLY_W-1:0] : GLYPH_DOT;
    push_o      = accept;
    if (op_i == OP_RESTART) begin
      cmd_o.kind = KIND_RESTART;
    end else if (data_byte_i == CH_NL) begin
      cmd_o.kind = KIND_NEWLINE;
    end else if (data_byte_i == CH_TAB) begin
      cmd_o.kind  = KIND_TAB;
      cmd_o.glyph = GLYPH_SPACE;
    end else if (data_byte_i == CH_CR) begin
      push_o = 1'b0;
    end
  end

endmodule

>>> design/twtl_queue.sv
// Short command queue that decouples the front end from the back end.
module twtl_queue import twtl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output cmd_t head_o,
  output logic empty_o,
  output logic full_o
);

  cmd_t              entry_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == QCNT_W'(QDEPTH));
  assign head_o  = entry_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !(push_i && !pop_i))
    else $error("command queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("command queue read while empty");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QDEPTH))
    else $error("command queue fill count out of range");
`endif

endmodule

>>> design/twtl_back.sv
// Back end: carries out layout commands, tracks line and column, emits cells.
module twtl_back import twtl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  layout_cfg_t       cfg_i,
  input  cmd_t              head_i,
  input  logic              q_empty_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [GLY_W-1:0]  glyph_code_o,
  output logic [ROW_W-1:0]  screen_row_o,
  output logic [COL_W-1:0]  screen_col_o,
  output logic              last_of_run_o
);

  // Layout state.
  logic [LC_W-1:0]   line_count_q, line_count_d;
  logic [COL_W-1:0]  column_q, column_d;
  logic [TPH_W-1:0]  phase_q, phase_d;
  logic              tab_busy_q, tab_busy_d;
  logic [TCNT_W-1:0] tab_left_q, tab_left_d;

  // Output register.
  logic              out_valid_q, out_valid_d;
  logic [GLY_W-1:0]  glyph_q;
  logic [ROW_W-1:0]  row_q;
  logic [COL_W-1:0]  col_q;
  logic              last_q;

  logic              slot_free;
  logic              step;
  logic              cur_open;
  logic              in_window;
  logic [LC_W-1:0]   lc_inc;
  logic [COL_W-1:0]  col_inc;
  logic [TPH_W-1:0]  phase_inc;
  logic              wrap;
  logic [LC_W-1:0]   adv_lc;
  logic              adv_open;
  logic [TCNT_W-1:0] spaces;
  logic [TCNT_W-1:0] rem;
  logic              do_cell;
  logic              do_tab;
  logic [GLY_W-1:0]  cell_glyph;
  logic              made;
  logic              last;

  // One step per cycle whenever the output slot can take a new word.
  assign slot_free = !out_valid_q || !out_stall_i;
  assign pop_o     = slot_free && !tab_busy_q && !q_empty_i;
  assign step      = slot_free && (tab_busy_q || !q_empty_i);

  // Position after placing a cell at the current spot.
  assign cur_open  = line_count_q < cfg_i.window_end;
  assign in_window = (line_count_q >= {1'b0, cfg_i.first_line}) && cur_open;
  assign lc_inc    = (line_count_q == LINE_MAX) ? line_count_q : line_count_q + 1'b1;
  assign col_inc   = column_q + 1'b1;
  assign phase_inc = (phase_q == TPH_W'(TAB_STOP - 1)) ? '0 : phase_q + 1'b1;
  assign wrap      = col_inc >= cfg_i.width;
  assign adv_lc    = wrap ? lc_inc : line_count_q;
  assign adv_open  = adv_lc < cfg_i.window_end;
  assign spaces    = TCNT_W'(TAB_STOP) - TCNT_W'(phase_q);

  // Command execution.
  always_comb begin
    line_count_d = line_count_q;
    column_d     = column_q;
    phase_d      = phase_q;
    tab_busy_d   = tab_busy_q;
    tab_left_d   = tab_left_q;
    do_cell      = 1'b0;
    do_tab       = 1'b0;
    cell_glyph   = head_i.glyph;
    rem          = '0;
    if (step) begin
      if (tab_busy_q) begin
        do_cell    = 1'b1;
        do_tab     = 1'b1;
        cell_glyph = GLYPH_SPACE;
        rem        = tab_left_q - 1'b1;
      end else begin
        unique case (head_i.kind)
          KIND_RESTART: begin
            line_count_d = '0;
            column_d     = '0;
            phase_d      = '0;
          end
          KIND_NEWLINE: begin
            if (cur_open) begin
              line_count_d = lc_inc;
              column_d     = '0;
              phase_d      = '0;
            end
          end
          KIND_GLYPH: begin
            do_cell = cur_open;
          end
          KIND_TAB: begin
            do_cell    = cur_open;
            do_tab     = cur_open;
            cell_glyph = GLYPH_SPACE;
            rem        = spaces - 1'b1;
          end
          default: begin
          end
        endcase
      end
      if (do_cell) begin
        line_count_d = adv_lc;
        column_d     = wrap ? '0 : col_inc;
        phase_d      = wrap ? '0 : phase_inc;
      end
      if (do_tab) begin
        tab_left_d = rem;
        tab_busy_d = (rem != '0) && adv_open;
      end
    end
  end

  // A cell inside a tab run is the last one when the run or the window ends.
  assign made = do_cell && in_window;
  assign last = do_tab ? ((rem == '0) || !adv_open) : 1'b1;

  assign out_valid_d = slot_free ? (step && made) : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_count_q <= '0;
      column_q     <= '0;
      phase_q      <= '0;
      tab_busy_q   <= 1'b0;
      tab_left_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      line_count_q <= line_count_d;
      column_q     <= column_d;
      phase_q      <= phase_d;
      tab_busy_q   <= tab_busy_d;
      tab_left_q   <= tab_left_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Output word payload.
  always_ff @(posedge clk_i) begin
    if (step && made) begin
      glyph_q <= cell_glyph;
      row_q   <= line_count_q[ROW_W-1:0] - cfg_i.first_line[ROW_W-1:0];
      col_q   <= column_q;
      last_q  <= last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign glyph_code_o  = glyph_q;
  assign screen_row_o  = row_q;
  assign screen_col_o  = col_q;
  assign last_of_run_o = last_q;

`ifndef ASSERT_OFF
  a_tab_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tab_busy_q |-> (tab_left_q != '0))
    else $error("tab run active with no cells left");
  a_tab_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tab_busy_q |-> cur_open)
    else $error("tab run continues past the end of the window");
  a_glyph_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((glyph_q >= GLYPH_LO) && (glyph_q <= GLYPH_HI)))
    else $error("non-printable glyph on the output");
  a_no_pop_in_tab: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tab_busy_q |-> !pop_o)
    else $error("queue popped during a tab run");
`endif

endmodule

>>> design/text_wrap_tab_layout.sv
// Top level of the text layout block: configuration registers and the pipeline.
// A result word passes through the command queue and the back end's output register, and
// waits behind any cells that the back end still has to place for earlier words.
// Throughput: one input word per cycle while the queue has room; a tab places one cell
// per cycle in the back end while the output is not stalled, up to four cells per tab.
// Reset clears line, column, queue and output; registers return to 0, 28, 77.
module text_wrap_tab_layout import twtl_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write channel.
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [FL_W-1:0]      cfg_data_i,
  // Input channel.
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 op_i,
  input  logic [BYTE_W-1:0]    data_byte_i,
  // Output channel.
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [GLY_W-1:0]     glyph_code_o,
  output logic [ROW_W-1:0]     screen_row_o,
  output logic [COL_W-1:0]     screen_col_o,
  output logic                 last_of_run_o
);

  logic [FL_W-1:0] first_line_q;
  logic [WR_W-1:0] window_rows_q;
  logic [LW_W-1:0] line_width_q;
  logic [WR_W-1:0] rows_eff;
  layout_cfg_t     cfg;
  logic            push;
  cmd_t            cmd;
  cmd_t            head;
  logic            q_empty;
  logic            q_full;
  logic            pop;

  // Configuration registers, always ready.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_line_q  <= FIRST_LINE_RST;
      window_rows_q <= WINDOW_ROWS_RST;
      line_width_q  <= LINE_WIDTH_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_FIRST_LINE) begin
        first_line_q <= cfg_data_i;
      end
      if (cfg_index_i == CFG_WINDOW_ROWS) begin
        window_rows_q <= cfg_data_i[WR_W-1:0];
      end
      if (cfg_index_i == CFG_LINE_WIDTH) begin
        line_width_q <= cfg_data_i[LW_W-1:0];
      end
    end
  end

  // Clamp the settings: at most 64 rows, and a zero width acts as one.
  assign rows_eff       = (window_rows_q > ROWS_MAX) ? ROWS_MAX : window_rows_q;
  assign cfg.first_line = first_line_q;
  assign cfg.window_end = {1'b0, first_line_q} + LC_W'(rows_eff);
  assign cfg.width      = (line_width_q == '0) ? LW_W'(1) : line_width_q;

  twtl_front u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .data_byte_i (data_byte_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .cmd_o       (cmd)
  );

  twtl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  twtl_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .head_i        (head),
    .q_empty_i     (q_empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .glyph_code_o  (glyph_code_o),
    .screen_row_o  (screen_row_o),
    .screen_col_o  (screen_col_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

>>> verif/twtl_checker.sv
// Checker for the text layout block: predicts every output cell and compares the result words.
module twtl_checker import twtl_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [FL_W-1:0]      cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic                 op_i,
  input  logic [BYTE_W-1:0]    data_byte_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [GLY_W-1:0]     glyph_code_i,
  input  logic [ROW_W-1:0]     screen_row_i,
  input  logic [COL_W-1:0]     screen_col_i,
  input  logic                 last_of_run_i,
  output int                   mismatch_count_o,
  output int                   cells_due_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [GLY_W-1:0] glyph;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } glyph_cell_t;

  // Layout settings and position as this checker tracks them.
  logic [FL_W-1:0]  top_line = FIRST_LINE_RST;
  logic [WR_W-1:0]  rows     = WINDOW_ROWS_RST;
  logic [LW_W-1:0]  width    = LINE_WIDTH_RST;
  int               line_no  = 0;
  logic [COL_W-1:0] col_no   = '0;

  // Cells still owed by the block, oldest first, and the cells of the word being laid out.
  glyph_cell_t cells_due[$];
  glyph_cell_t run_cells[$];
  glyph_cell_t seen;
  glyph_cell_t due;

  // The window is open while the line counter has not passed its last line.
  function automatic bit window_open();
    int shown;
    shown = (rows > ROWS_MAX) ? int'(ROWS_MAX) : int'(rows);
    return line_no < int'(top_line) + shown;
  endfunction

  function automatic void next_line();
    if (line_no < int'(LINE_MAX)) begin
      line_no++;
    end
  endfunction

  // One cell: a result only inside the window, then the column advances and may wrap.
  function automatic void place_glyph(input logic [GLY_W-1:0] g);
    glyph_cell_t fresh;
    int          wrap_at;
    if (line_no >= int'(top_line) && window_open()) begin
      fresh.glyph = g;
      fresh.row   = ROW_W'(line_no - int'(top_line));
      fresh.col   = col_no;
      fresh.last  = 1'b0;
      run_cells.push_back(fresh);
    end
    wrap_at = (width == '0) ? 1 : int'(width);
    col_no  = col_no + 1'b1;
    if (int'(col_no) >= wrap_at) begin
      col_no = '0;
      next_line();
    end
  endfunction

  // Works out the cells caused by one accepted input word and queues them.
  function automatic void lay_out_word(input logic op, input logic [BYTE_W-1:0] b);
    int          spaces;
    glyph_cell_t c;
    run_cells.delete();
    if (op == OP_RESTART) begin
      line_no = 0;
      col_no  = '0;
    end else if (window_open()) begin
      if (b == CH_NL) begin
        col_no = '0;
        next_line();
      end else if (b == CH_CR) begin
        // Carriage returns are dropped.
      end else if (b == CH_TAB) begin
        spaces = TAB_STOP - (int'(col_no) % TAB_STOP);
        for (int s = 0; s < spaces && window_open(); s++) begin
          place_glyph(GLYPH_SPACE);
        end
      end else begin
        place_glyph((b >= CH_PRINT_LO && b <= CH_PRINT_HI) ? b[GLY_W-1:0] : GLYPH_DOT);
      end
    end
    foreach (run_cells[k]) begin
      c      = run_cells[k];
      c.last = (k == run_cells.size() - 1);
      cells_due.push_back(c);
    end
  endfunction

  function automatic void report(input string what, input int exp_v, input int got_v);
    $display("%0t: %s expected %0d, got %0d", $time, what, exp_v, got_v);
    mismatch_count_o++;
  endfunction

  // Result words are checked before this edge's input word is predicted: none can overtake.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        seen = '{glyph: glyph_code_i, row: screen_row_i, col: screen_col_i,
                 last: last_of_run_i};
        if (cells_due.size() == 0) begin
          $display("%0t: no cell expected, got glyph %0d row %0d col %0d last %0d",
                   $time, seen.glyph, seen.row, seen.col, seen.last);
          mismatch_count_o++;
        end else begin
          due = cells_due.pop_front();
          if (seen.glyph !== due.glyph) report("glyph_code", due.glyph, seen.glyph);
          if (seen.row !== due.row) report("screen_row", due.row, seen.row);
          if (seen.col !== due.col) report("screen_col", due.col, seen.col);
          if (seen.last !== due.last) report("last_of_run", due.last, seen.last);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_FIRST_LINE:  top_line = cfg_data_i;
          CFG_WINDOW_ROWS: rows     = cfg_data_i[WR_W-1:0];
          CFG_LINE_WIDTH:  width    = cfg_data_i[LW_W-1:0];
          default: begin
            // Unused index: nothing changes.
          end
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        lay_out_word(op_i, data_byte_i);
      end
      cells_due_o = cells_due.size();
    end
  end

endmodule

>>> verif/tb_text_wrap_tab_layout.sv
// Testbench top of the text layout block: clock, reset, stimulus, receiver stalls and verdict.
module tb_text_wrap_tab_layout import twtl_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD = 300;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [FL_W-1:0]      cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 op_i;
  logic [BYTE_W-1:0]    data_byte_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [GLY_W-1:0]     glyph_code_o;
  logic [ROW_W-1:0]     screen_row_o;
  logic [COL_W-1:0]     screen_col_o;
  logic                 last_of_run_o;

  int mismatches;
  int cells_due;
  int burst_left = 0;
  int cycles = 0;
  bit hold_req = 1'b0;

  always #6 clk_i = ~clk_i;

  text_wrap_tab_layout u_top (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .op_i, .data_byte_i,
    .out_valid_o, .out_stall_i, .glyph_code_o, .screen_row_o, .screen_col_o, .last_of_run_o
  );

  twtl_checker u_check (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .op_i, .data_byte_i,
    .out_valid_i(out_valid_o), .out_stall_i, .glyph_code_i(glyph_code_o),
    .screen_row_i(screen_row_o), .screen_col_i(screen_col_o), .last_of_run_i(last_of_run_o),
    .mismatch_count_o(mismatches), .cells_due_o(cells_due)
  );

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: stall patterns of random density, and one long hold-off when asked.
  initial begin
    int span;
    int pct;
    int hold_left;
    bit held;
    span = 0;
    pct = 0;
    hold_left = 0;
    held = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !held) begin
        held = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (span == 0) begin
          span = $urandom_range(10, 80);
          case ($urandom_range(0, 3))
            0:       pct = 0;
            1:       pct = 20;
            2:       pct = 50;
            default: pct = 85;
          endcase
        end
        span--;
        out_stall_i <= ($urandom_range(0, 99) < pct);
      end
    end
  end

  // Offers one input word in bursts with random gaps, and waits until it is taken.
  task automatic put(input logic op, input logic [BYTE_W-1:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i  <= 1'b1;
    op_i        <= op;
    data_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Random text: mostly printable runs broken by newlines and tabs, with some noise.
  task automatic put_random_text(input int count);
    int r;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 3)       put(OP_RESTART, BYTE_W'($urandom_range(0, 255)));
      else if (r < 13) put(OP_TEXT, CH_NL);
      else if (r < 25) put(OP_TEXT, CH_TAB);
      else if (r < 28) put(OP_TEXT, CH_CR);
      else if (r < 36) put(OP_TEXT, BYTE_W'($urandom_range(0, 255)));
      else             put(OP_TEXT, BYTE_W'($urandom_range(32, 126)));
    end
  endtask

  // Waits until every expected cell has arrived and the block has run dry.
  task automatic settle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(negedge clk_i);
    while (cells_due != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes the three layout registers back to back, optionally the unused index first.
  task automatic cfg_set(input logic [FL_W-1:0] fl, input logic [WR_W-1:0] wr,
                         input logic [LW_W-1:0] lw, input bit spare);
    logic [CFG_IDX_W-1:0] idx[$];
    logic [FL_W-1:0]      val[$];
    logic [FL_W-1:0]      noise;
    if (spare) begin
      idx.push_back(CFG_SPARE);
      val.push_back(FL_W'($urandom));
    end
    idx.push_back(CFG_FIRST_LINE);
    val.push_back(fl);
    // Upper data bits are junk: only the low bits of these registers count.
    noise = FL_W'($urandom);
    noise[WR_W-1:0] = wr;
    idx.push_back(CFG_WINDOW_ROWS);
    val.push_back(noise);
    noise = FL_W'($urandom);
    noise[LW_W-1:0] = lw;
    idx.push_back(CFG_LINE_WIDTH);
    val.push_back(noise);
    foreach (idx[k]) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[k];
      cfg_data_i  <= val[k];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    in_valid_i  = 1'b0;
    op_i        = OP_TEXT;
    data_byte_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_FIRST_LINE;
    cfg_data_i  = '0;
    rst_ni      = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: glyph extremes, non-printables, carriage return, tabs at
    // several columns, newline and restart.
    put(OP_TEXT, "A");
    put(OP_TEXT, 8'd32);
    put(OP_TEXT, 8'd126);
    put(OP_TEXT, 8'd31);
    put(OP_TEXT, 8'd127);
    put(OP_TEXT, 8'h00);
    put(OP_TEXT, 8'hFF);
    put(OP_TEXT, 8'h80);
    put(OP_TEXT, CH_CR);
    put(OP_TEXT, CH_TAB);
    put(OP_TEXT, "x");
    put(OP_TEXT, CH_TAB);
    put(OP_TEXT, "y");
    put(OP_TEXT, "z");
    put(OP_TEXT, CH_TAB);
    put(OP_TEXT, "q");
    put(OP_TEXT, CH_TAB);
    put(OP_TEXT, CH_NL);
    put(OP_TEXT, CH_TAB);
    put(OP_RESTART, 8'hFF);
    put(OP_TEXT, "B");
    put(OP_TEXT, CH_NL);
    put(OP_RESTART, 8'h00);
    put_random_text(70);

    // Widest window and line; the receiver holds off for a long stretch meanwhile.
    settle();
    cfg_set(16'd0, 7'd64, 7'd127, 1'b1);
    hold_req <= 1'b1;
    put(OP_RESTART, 8'h00);
    put_random_text(100);

    // One-column lines and a two-line window below the top: a tab partly above
    // the window, a tab cut short when the window fills, then ignored words.
    settle();
    cfg_set(16'd3, 7'd2, 7'd1, 1'b0);
    put(OP_RESTART, 8'h00);
    put(OP_TEXT, CH_TAB);
    put(OP_TEXT, CH_TAB);
    put(OP_TEXT, "a");
    put(OP_TEXT, CH_TAB);
    put_random_text(50);

    // Oversized window clamps to 64 rows, zero width acts as one column.
    settle();
    cfg_set(16'd1, 7'd100, 7'd0, 1'b0);
    put(OP_RESTART, 8'h00);
    put_random_text(80);

    // Empty window: nothing comes out.
    settle();
    cfg_set(16'd0, 7'd0, 7'd5, 1'b0);
    put(OP_RESTART, 8'h00);
    put(OP_TEXT, "a");
    put(OP_TEXT, CH_TAB);
    put(OP_TEXT, CH_NL);
    put_random_text(10);

    // Highest top line: the window is never reached.
    settle();
    cfg_set(16'hFFFF, 7'd127, 7'd10, 1'b0);
    put(OP_RESTART, 8'h00);
    put_random_text(20);

    // Narrowing the line under a column already past the new width.
    settle();
    cfg_set(16'd0, 7'd28, 7'd77, 1'b0);
    put(OP_RESTART, 8'h00);
    repeat (40) put(OP_TEXT, BYTE_W'($urandom_range(33, 126)));
    settle();
    cfg_set(16'd0, 7'd28, 7'd9, 1'b0);
    put(OP_TEXT, "n");
    put(OP_TEXT, "m");
    put(OP_TEXT, CH_TAB);
    put_random_text(70);

    // Narrow lines scrolling down to a window further into the text.
    settle();
    cfg_set(16'd40, 7'd5, 7'd1, 1'b0);
    put(OP_RESTART, 8'h00);
    put_random_text(60);

    settle();
    @(negedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
